// ===== sv/nljp_pkg.sv =====
// Shared types and constants for the nested-loop join probe core.
package nljp_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int FIELD_BITS_DEF  = 32;
   localparam int IO_BITS         = 32;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_PROBE = 1'b1
   } op_type;

   typedef struct packed {
      logic               operation;
      logic               chunk_start;
      logic [IO_BITS-1:0] tuple_key;
      logic [IO_BITS-1:0] tuple_value;
   } req_type;

   typedef struct packed {
      logic [IO_BITS-1:0] result_key;
      logic [IO_BITS-1:0] result_payload;
      logic               matched;
      logic               table_overflow;
   } rsp_type;

   // Decoded command handed from the front end to the back end.
   typedef struct packed {
      op_type             op;
      logic               chunk_start;
      logic [IO_BITS-1:0] key;
      logic [IO_BITS-1:0] value;
   } cmd_type;

endpackage

// ===== sv/nljp_front.sv =====
// Front end: accepts request beats, decodes them and queues commands.
module nljp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nljp_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output nljp_pkg::cmd_type cmd_data
);

   localparam int PTR_W = (nljp_pkg::QUEUE_DEPTH > 1) ? $clog2(nljp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(nljp_pkg::QUEUE_DEPTH + 1);

   nljp_pkg::cmd_type q_ff [nljp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   nljp_pkg::cmd_type dec_cmd;
   logic              push;
   logic              pop;

   always_comb begin
      dec_cmd.op          = nljp_pkg::op_type'(req_data.operation);
      dec_cmd.chunk_start = req_data.chunk_start;
      dec_cmd.key         = req_data.tuple_key;
      dec_cmd.value       = req_data.tuple_value;
   end

   assign req_ready = (fill_ff != CNT_W'(nljp_pkg::QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(nljp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(nljp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(nljp_pkg::QUEUE_DEPTH))
      else $error("queue fill above depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("queue fill missed a push");
`endif

endmodule

// ===== sv/nljp_back.sv =====
// Back end: table memory, load execution, probe scan and result register.
module nljp_back #(
   parameter int TABLE_DEPTH = nljp_pkg::TABLE_DEPTH_DEF,
   parameter int FIELD_BITS  = nljp_pkg::FIELD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  nljp_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nljp_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   logic [2*FIELD_BITS-1:0] mem [TABLE_DEPTH];
   logic [2*FIELD_BITS-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              pend_ff, pend_in;
   logic [FIELD_BITS-1:0] probe_key_ff, probe_key_in;
   logic [FIELD_BITS-1:0] probe_val_ff, probe_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   nljp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [FIELD_BITS-1:0] cmd_key;
   logic [FIELD_BITS-1:0] cmd_val;
   logic [CNT_W-1:0]      load_base;
   logic                  mem_we;
   logic                  rd_en;
   logic                  cmp_hit;
   logic                  hit;
   logic                  finish;
   logic                  out_free;
   logic                  out_load;
   logic                  take;

   assign cmd_key = FIELD_BITS'(cmd_data.key);
   assign cmd_val = FIELD_BITS'(cmd_data.value);

   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign load_base = cmd_data.chunk_start ? '0 : count_ff;
   assign mem_we    = take && (cmd_data.op == nljp_pkg::OP_LOAD)
                      && (load_base < CNT_W'(TABLE_DEPTH));

   assign cmp_hit = (rd_data_ff[2*FIELD_BITS-1:FIELD_BITS] == probe_key_ff);
   assign hit     = pend_ff && cmp_hit;
   // Scan ends on the first hit, or once every loaded entry has been compared.
   assign finish  = (state_ff == ST_SCAN)
                    && (hit || (scan_idx_ff == count_ff));
   assign out_load = finish && out_free;
   assign rd_en   = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff) && !hit;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      scan_idx_in  = scan_idx_ff;
      probe_key_in = probe_key_ff;
      probe_val_in = probe_val_ff;
      // Hold the compared entry while the result waits for a free slot.
      pend_in      = rd_en || (pend_ff && finish && !out_free);
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd_data.op == nljp_pkg::OP_LOAD) begin
                  if (cmd_data.chunk_start) begin
                     overflow_in = 1'b0;
                  end
                  if (load_base < CNT_W'(TABLE_DEPTH)) begin
                     count_in = load_base + 1'b1;
                  end else begin
                     count_in    = load_base;
                     overflow_in = 1'b1;
                  end
               end else begin
                  probe_key_in = cmd_key;
                  probe_val_in = cmd_val;
                  scan_idx_in  = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in                = rsp_data_ff;
      rsp_data_in.result_key     = hit ? nljp_pkg::IO_BITS'(rd_data_ff[FIELD_BITS-1:0])
                                       : nljp_pkg::IO_BITS'(probe_key_ff);
      rsp_data_in.result_payload = nljp_pkg::IO_BITS'(probe_val_ff);
      rsp_data_in.matched        = hit;
      rsp_data_in.table_overflow = overflow_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_key_ff <= probe_key_in;
      probe_val_ff <= probe_val_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[load_base[IDX_W-1:0]] <= {cmd_key, cmd_val};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= count_ff))
      else $error("scan index past loaded entries");
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == CNT_W'(TABLE_DEPTH)))
      else $error("overflow flagged with room in table");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("compare pending outside a scan");
   a_result_from_scan: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("result not presented after scan end");
`endif

endmodule

// ===== sv/nested_loop_join_probe_core.sv =====
// Top level of the nested-loop join probe core.
// Holds one chunk of up to TABLE_DEPTH build tuples (key, value) in a single-port
// table memory. A load beat appends one tuple (chunk_start first empties the table);
// loads past the depth are dropped and reported through table_overflow on later
// probes. A probe beat scans the loaded entries from index 0 and the first key match
// replaces the probe key with that entry's value. The front end takes one request
// beat per cycle, while it has room, into a two-entry command queue; the back end
// accepts a command only in its idle state, and a probe compares one registered
// memory read per cycle until the scan ends, stopping early when a match is found.
// No clearing pass runs after reset.
module nested_loop_join_probe_core #(
   parameter int TABLE_DEPTH = nljp_pkg::TABLE_DEPTH_DEF,
   parameter int FIELD_BITS  = nljp_pkg::FIELD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nljp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nljp_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_ready;
   nljp_pkg::cmd_type cmd_data;

   nljp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   nljp_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FIELD_BITS  (FIELD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
